@@ hdl/etf_pkg.sv @@
// Shared types, constants and microprogram for the escape-time fractal pixel block.
// Depends on nothing; every other file in hdl/ imports it.
`default_nettype none

package etf_pkg;

    // Field widths that do not vary
    localparam int CAP_W         = 16;
    localparam int COLOUR_W      = 24;
    localparam int OUT_W         = 40;
    localparam int DENSITY_SHIFT = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int DCNT_W        = 5;

    localparam logic [COLOUR_W-1:0] COLOUR_SPAN = 24'hFF_FFFF;

    // Register reset values, trimmed to the configured widths where used
    localparam logic [CAP_W-1:0] ITER_CAP_RST = 16'd1000;
    localparam logic [63:0]      X_ORIGIN_RST = 64'hFFFF_FFFF_D800_0000;
    localparam logic [63:0]      Y_ORIGIN_RST = 64'hFFFF_FFFF_F000_0000;
    localparam logic [63:0]      X_STEP_RST   = 64'd734003;
    localparam logic [63:0]      Y_STEP_RST   = 64'd671089;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ITER_CAP = 3'd0,
        REG_X_ORIGIN = 3'd1,
        REG_Y_ORIGIN = 3'd2,
        REG_X_STEP   = 3'd3,
        REG_Y_STEP   = 3'd4
    } cfg_reg_t;

    // Microprogram addressing
    localparam int UADDR_W = 5;
    localparam logic [UADDR_W-1:0] UA_IDLE = 5'd0;
    localparam logic [UADDR_W-1:0] UA_LOOP = 5'd4;
    localparam logic [UADDR_W-1:0] UA_DIV  = 5'd20;
    localparam logic [UADDR_W-1:0] UA_LAST = 5'd23;

    // Sequencing conditions
    typedef enum logic [2:0] {
        JC_NEXT,     // fall through
        JC_JUMP,     // unconditional jump to target
        JC_HOLD_IN,  // wait here for an input transaction
        JC_ITER,     // to target while the pixel keeps iterating
        JC_DIV,      // to target while the divider has steps left
        JC_EMIT      // to target once the output register is free
    } jump_t;

    typedef enum logic [1:0] {
        CS_NONE,
        CS_X,
        CS_Y
    } coord_sel_t;

    // Operand pairs issued to the shared multiplier
    typedef enum logic [2:0] {
        MS_NONE,
        MS_ZR_ZR,
        MS_ZI_ZI,
        MS_ZR_ZI,
        MS_NR_NR,
        MS_NI_NI
    } mul_sel_t;

    // Destination for the multiplier result
    typedef enum logic [2:0] {
        CP_NONE,
        CP_RR,
        CP_II,
        CP_RI,
        CP_SQA,
        CP_SQB
    } cap_sel_t;

    typedef enum logic [2:0] {
        AL_NONE,
        AL_INIT,
        AL_FORM,
        AL_TEST,
        AL_DIV_INIT,
        AL_DIV_STEP,
        AL_COL_MUL,
        AL_COL_MOD
    } alu_op_t;

    // One control word
    typedef struct packed {
        jump_t               jc;
        logic [UADDR_W-1:0]  target;
        coord_sel_t          cmul;
        coord_sel_t          cadd;
        mul_sel_t            mul;
        cap_sel_t            cap;
        alu_op_t             alu;
    } uword_t;

    // Conditions fed back to the sequencer
    typedef struct packed {
        logic in_fire;
        logic iter_go;
        logic div_more;
        logic out_free;
    } seq_status_t;

    // Control store. The multiplier has four stages, so each product is captured at
    // the step at which it leaves the fourth stage.
    function automatic uword_t ucode_rom(input logic [UADDR_W-1:0] addr);
        uword_t w;
        w = '{jc: JC_NEXT, target: UA_IDLE, cmul: CS_NONE, cadd: CS_NONE,
              mul: MS_NONE, cap: CP_NONE, alu: AL_NONE};
        unique case (addr)
            5'd0: w.jc = JC_HOLD_IN;                       // take column and row
            5'd1: w.cmul = CS_X;                           // column * x_step
            5'd2: begin                                    // real part of c
                w.cadd = CS_X;
                w.cmul = CS_Y;
            end
            5'd3: begin                                    // imaginary part, z = 0
                w.cadd = CS_Y;
                w.alu  = AL_INIT;
            end
            5'd4:  w.mul = MS_ZR_ZR;
            5'd5:  w.mul = MS_ZI_ZI;
            5'd6:  w.mul = MS_ZR_ZI;
            5'd7:  w.jc  = JC_NEXT;
            5'd8:  w.cap = CP_RR;
            5'd9:  w.cap = CP_II;
            5'd10: w.cap = CP_RI;
            5'd11: w.alu = AL_FORM;                        // new z at guard width
            5'd12: w.mul = MS_NR_NR;
            5'd13: w.mul = MS_NI_NI;
            5'd14: w.jc  = JC_NEXT;
            5'd15: w.jc  = JC_NEXT;
            5'd16: w.cap = CP_SQA;
            5'd17: w.cap = CP_SQB;
            5'd18: begin                                   // escape test
                w.alu    = AL_TEST;
                w.jc     = JC_ITER;
                w.target = UA_LOOP;
            end
            5'd19: w.alu = AL_DIV_INIT;
            5'd20: begin
                w.alu    = AL_DIV_STEP;
                w.jc     = JC_DIV;
                w.target = UA_DIV;
            end
            5'd21: w.alu = AL_COL_MUL;
            5'd22: w.alu = AL_COL_MOD;
            5'd23: begin
                w.jc     = JC_EMIT;
                w.target = UA_IDLE;
            end
            default: w.jc = JC_JUMP;                       // unused, back to idle
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hdl/escape_time_fractal_pixel_top.sv @@
// Top level of the escape-time fractal pixel block: configuration registers,
// coordinate and iteration datapath, output register. Uses etf_pkg, etf_mul,
// etf_seq and etf_colour.
`default_nettype none

// Takes one pixel (column, row) per input transaction and returns its escape
// count and colour in one output transaction. c is origin + index * step in
// signed fixed point; z = z*z + c runs from zero until |z|^2 exceeds 4 or the
// iteration cap is reached. A microprogram steps one shared four-stage
// multiplier through the five products of each pass. After the last pass come
// a 24-step division for the colour scale, the colour product and reduction,
// and the output hand-over. One pixel is in work at a time; the next is taken
// as soon as the finished result sits in the output register. The user must
// write configuration only while no pixel is in work; the block itself does
// not enforce this.
module escape_time_fractal_pixel_top
    import etf_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28,
    parameter int INDEX_WIDTH = 12
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [COORD_WIDTH-1:0]            cfg_wdata,
    // pixel input: column, row
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((2*INDEX_WIDTH+7)/8)*8-1:0] s_tdata,
    // result: red, green, blue, escape_count
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [OUT_W-1:0]                       m_tdata
);

    localparam int CW  = COORD_WIDTH;
    localparam int IW  = INDEX_WIDTH;
    localparam int GW  = CW + 3;
    localparam int PRW = IW + CW - 1;
    localparam int TW  = (GW + 1 > FRAC_BITS + 4) ? GW + 1 : FRAC_BITS + 4;

    localparam logic signed [GW+1:0] G_HI = $signed({3'b000, {(GW-1){1'b1}}});
    localparam logic signed [GW+1:0] G_LO = $signed({3'b111, {(GW-1){1'b0}}});
    localparam logic signed [GW-1:0] C_HI = $signed({4'b0000, {(CW-1){1'b1}}});
    localparam logic signed [GW-1:0] C_LO = $signed({4'b1111, {(CW-1){1'b0}}});
    localparam logic signed [CW+1:0] CS_HI = $signed({3'b000, {(CW-1){1'b1}}});
    localparam logic [TW-1:0]        FOUR = {{(TW-1){1'b0}}, 1'b1} << (FRAC_BITS + 2);

    // configuration registers
    logic [CAP_W-1:0]     cap_reg;
    logic signed [CW-1:0] x_origin_reg, y_origin_reg;
    logic [CW-2:0]        x_step_reg, y_step_reg;
    logic [CAP_W-1:0]     cap_eff;

    // pixel datapath
    logic [IW-1:0]        col_reg, row_reg;
    logic [PRW-1:0]       cprod_reg, cprod_next;
    logic signed [CW-1:0] cr_reg, ci_reg, cr_next, ci_next;
    logic signed [CW-1:0] zr_reg, zi_reg, zr_next, zi_next;
    logic signed [GW-1:0] prr_reg, pii_reg, pri_reg, sqa_reg, sqb_reg;
    logic signed [GW-1:0] nr_reg, ni_reg, nr_next, ni_next;
    logic [CAP_W-1:0]     iter_reg, iter_next, count_reg, count_next;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg;

    uword_t               ctrl;
    seq_status_t          status;
    logic                 in_fire, out_free, out_load, esc, last, div_more;
    logic signed [GW-1:0] mul_a, mul_b, mul_p, zr_g, zi_g;
    logic signed [CW-1:0] c_origin;
    logic                 c_ovf;
    logic signed [CW+1:0] c_sum;
    logic signed [CW-1:0] c_val;
    logic signed [GW+1:0] nr_full, ni_full;
    logic [TW-1:0]        sq_sum;
    logic [COLOUR_W-1:0]  colour;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= ITER_CAP_RST;
            x_origin_reg <= X_ORIGIN_RST[CW-1:0];
            y_origin_reg <= Y_ORIGIN_RST[CW-1:0];
            x_step_reg   <= X_STEP_RST[CW-2:0];
            y_step_reg   <= Y_STEP_RST[CW-2:0];
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ITER_CAP: cap_reg      <= cfg_wdata[CAP_W-1:0];
                REG_X_ORIGIN: x_origin_reg <= cfg_wdata;
                REG_Y_ORIGIN: y_origin_reg <= cfg_wdata;
                REG_X_STEP:   x_step_reg   <= cfg_wdata[CW-2:0];
                REG_Y_STEP:   y_step_reg   <= cfg_wdata[CW-2:0];
                default: ;
            endcase
        end
    end

    assign cap_eff = (cap_reg == '0) ? CAP_W'(1) : cap_reg;

    // sequencer and handshake status; no transaction is taken in reset
    assign s_tready = aresetn && (ctrl.jc == JC_HOLD_IN);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (ctrl.jc == JC_EMIT) && out_free;

    assign status = '{in_fire: in_fire, iter_go: !esc && !last,
                      div_more: div_more, out_free: out_free};

    etf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // coordinate: index * step, then origin + product with saturation
    always_comb begin
        cprod_next = cprod_reg;
        case (ctrl.cmul)
            CS_X:    cprod_next = col_reg * x_step_reg;
            CS_Y:    cprod_next = row_reg * y_step_reg;
            default: ;
        endcase
    end

    always_comb begin
        c_origin = (ctrl.cadd == CS_Y) ? y_origin_reg : x_origin_reg;
        c_ovf    = |cprod_reg[PRW-1:CW];
        c_sum    = (CW+2)'(c_origin) + $signed({2'b00, cprod_reg[CW-1:0]});
        c_val    = (c_ovf || (c_sum > CS_HI)) ? CS_HI[CW-1:0] : c_sum[CW-1:0];
        cr_next  = (ctrl.cadd == CS_X) ? c_val : cr_reg;
        ci_next  = (ctrl.cadd == CS_Y) ? c_val : ci_reg;
    end

    // multiplier operands
    assign zr_g = {{3{zr_reg[CW-1]}}, zr_reg};
    assign zi_g = {{3{zi_reg[CW-1]}}, zi_reg};

    always_comb begin
        case (ctrl.mul)
            MS_ZR_ZR: begin mul_a = zr_g;   mul_b = zr_g;   end
            MS_ZI_ZI: begin mul_a = zi_g;   mul_b = zi_g;   end
            MS_ZR_ZI: begin mul_a = zr_g;   mul_b = zi_g;   end
            MS_NR_NR: begin mul_a = nr_reg; mul_b = nr_reg; end
            MS_NI_NI: begin mul_a = ni_reg; mul_b = ni_reg; end
            default:  begin mul_a = '0;     mul_b = '0;     end
        endcase
    end

    etf_mul #(
        .GW   (GW),
        .FRAC (FRAC_BITS)
    ) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    // new z at guard width, escape test
    always_comb begin
        nr_full = (GW+2)'(prr_reg) - (GW+2)'(pii_reg) + (GW+2)'(cr_reg);
        ni_full = ((GW+2)'(pri_reg) <<< 1) + (GW+2)'(ci_reg);
        nr_next = (nr_full > G_HI) ? G_HI[GW-1:0] :
                  (nr_full < G_LO) ? G_LO[GW-1:0] : nr_full[GW-1:0];
        ni_next = (ni_full > G_HI) ? G_HI[GW-1:0] :
                  (ni_full < G_LO) ? G_LO[GW-1:0] : ni_full[GW-1:0];
        sq_sum  = TW'($unsigned(sqa_reg)) + TW'($unsigned(sqb_reg));
        esc     = sq_sum > FOUR;
        last    = ({1'b0, iter_reg} + 1'b1) == {1'b0, cap_eff};
    end

    // iteration state
    always_comb begin
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        iter_next  = iter_reg;
        count_next = count_reg;
        case (ctrl.alu)
            AL_INIT: begin
                zr_next   = '0;
                zi_next   = '0;
                iter_next = '0;
            end
            AL_TEST: begin
                if (esc) begin
                    count_next = iter_reg;
                end else if (last) begin
                    count_next = '0;
                end else begin
                    zr_next   = (nr_reg > C_HI) ? C_HI[CW-1:0] :
                                (nr_reg < C_LO) ? C_LO[CW-1:0] : nr_reg[CW-1:0];
                    zi_next   = (ni_reg > C_HI) ? C_HI[CW-1:0] :
                                (ni_reg < C_LO) ? C_LO[CW-1:0] : ni_reg[CW-1:0];
                    iter_next = iter_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            col_reg <= s_tdata[IW-1:0];
            row_reg <= s_tdata[2*IW-1:IW];
        end
        cprod_reg <= cprod_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        iter_reg  <= iter_next;
        count_reg <= count_next;
        if (ctrl.alu == AL_FORM) begin
            nr_reg <= nr_next;
            ni_reg <= ni_next;
        end
        // capture multiplier results
        case (ctrl.cap)
            CP_RR:   prr_reg <= mul_p;
            CP_II:   pii_reg <= mul_p;
            CP_RI:   pri_reg <= mul_p;
            CP_SQA:  sqa_reg <= mul_p;
            CP_SQB:  sqb_reg <= mul_p;
            default: ;
        endcase
    end

    etf_colour u_colour (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .alu      (ctrl.alu),
        .cap      (cap_eff),
        .count    (count_reg),
        .div_more (div_more),
        .colour   (colour)
    );

    // output register
    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (out_load) begin
            out_data_reg <= {count_reg, colour};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_one_pixel_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second pixel taken while one is in work");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(ctrl.jc == JC_EMIT))
        else $error("result raised outside the emit step");

endmodule

`default_nettype wire

@@ hdl/etf_mul.sv @@
// Four-stage signed fixed-point multiplier: magnitude, partial products, sum,
// then shift, saturate and sign. Imports etf_pkg.
`default_nettype none

module etf_mul
    import etf_pkg::*;
#(
    parameter int GW   = 35,
    parameter int FRAC = 28
) (
    input  wire logic                 aclk,
    input  wire logic signed [GW-1:0] a,
    input  wire logic signed [GW-1:0] b,
    output logic signed [GW-1:0]      p
);

    localparam int H  = (GW + 1) / 2;
    localparam int HW = GW - H;
    localparam int PW = (GW > FRAC) ? 2 * GW : FRAC + GW;
    localparam int QW = PW - FRAC;

    logic [GW-1:0]     ma_reg, mb_reg;
    logic              neg1_reg, neg2_reg, neg3_reg;
    logic [2*H-1:0]    pp_ll_reg;
    logic [H+HW-1:0]   pp_lh_reg, pp_hl_reg;
    logic [2*HW-1:0]   pp_hh_reg;
    logic [PW-1:0]     sum_reg;
    logic signed [GW-1:0] p_reg;

    logic [GW-1:0]     ma_next, mb_next;
    logic [QW-1:0]     q;
    logic              over;
    logic [GW-2:0]     mag;
    logic [GW-1:0]     p_next;

    // stage 1: magnitudes
    always_comb begin
        ma_next = a[GW-1] ? (~a + 1'b1) : a;
        mb_next = b[GW-1] ? (~b + 1'b1) : b;
    end

    // stage 4: truncate toward zero, saturate, restore sign
    always_comb begin
        q      = sum_reg[PW-1:FRAC];
        over   = |q[QW-1:GW-1];
        mag    = over ? {(GW-1){1'b1}} : q[GW-2:0];
        p_next = neg3_reg ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};
    end

    always_ff @(posedge aclk) begin
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        neg1_reg  <= a[GW-1] ^ b[GW-1];
        // stage 2: four narrow partial products
        pp_ll_reg <= ma_reg[H-1:0] * mb_reg[H-1:0];
        pp_lh_reg <= ma_reg[H-1:0] * mb_reg[GW-1:H];
        pp_hl_reg <= ma_reg[GW-1:H] * mb_reg[H-1:0];
        pp_hh_reg <= ma_reg[GW-1:H] * mb_reg[GW-1:H];
        neg2_reg  <= neg1_reg;
        // stage 3: recombine
        sum_reg   <= PW'(pp_ll_reg) + (PW'(pp_lh_reg) << H) + (PW'(pp_hl_reg) << H)
                   + (PW'(pp_hh_reg) << (2 * H));
        neg3_reg  <= neg2_reg;
        p_reg     <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ hdl/etf_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Imports etf_pkg for the control word, status struct and microprogram.
`default_nettype none

module etf_seq
    import etf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire seq_status_t status,
    output uword_t           ctrl
);

    logic [UADDR_W-1:0] pc_reg, pc_next, pc_inc;

    assign ctrl   = ucode_rom(pc_reg);
    assign pc_inc = pc_reg + 1'b1;

    // next step
    always_comb begin
        unique case (ctrl.jc)
            JC_NEXT:    pc_next = pc_inc;
            JC_JUMP:    pc_next = ctrl.target;
            JC_HOLD_IN: pc_next = status.in_fire  ? pc_inc      : pc_reg;
            JC_ITER:    pc_next = status.iter_go  ? ctrl.target : pc_inc;
            JC_DIV:     pc_next = status.div_more ? ctrl.target : pc_inc;
            JC_EMIT:    pc_next = status.out_free ? ctrl.target : pc_reg;
            default:    pc_next = UA_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= UA_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    a_pc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= UA_LAST)
        else $error("sequencer left the microprogram");

endmodule

`default_nettype wire

@@ hdl/etf_colour.sv @@
// Colour unit: restoring divider for floor(0xFFFFFF/cap), count product and
// reduction modulo 0xFFFFFF. Imports etf_pkg.
`default_nettype none

module etf_colour
    import etf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire alu_op_t          alu,
    input  wire logic [CAP_W-1:0] cap,
    input  wire logic [CAP_W-1:0] count,
    output logic                  div_more,
    output logic [COLOUR_W-1:0]   colour
);

    localparam int PROD_W = CAP_W + COLOUR_W;
    localparam int V_W    = PROD_W + DENSITY_SHIFT;

    logic [CAP_W-1:0]    rem_reg, rem_next;
    logic [COLOUR_W-1:0] quo_reg, quo_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [COLOUR_W-1:0] colour_reg, colour_next;

    logic [CAP_W+1:0]    trial;
    logic                take;
    logic [V_W-1:0]      v;
    logic [COLOUR_W:0]   fold;

    // one quotient bit a step
    always_comb begin
        trial = {1'b0, rem_reg, quo_reg[COLOUR_W-1]} - {2'b00, cap};
        take  = !trial[CAP_W+1];
    end

    // fold the product modulo 2^24 - 1; the value stays below 16 * span
    always_comb begin
        v    = {prod_reg, {DENSITY_SHIFT{1'b0}}};
        fold = {1'b0, v[COLOUR_W-1:0]} + (COLOUR_W+1)'(v[V_W-1:COLOUR_W]);
    end

    always_comb begin
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dcnt_next   = dcnt_reg;
        prod_next   = prod_reg;
        colour_next = colour_reg;
        unique case (alu)
            AL_DIV_INIT: begin
                rem_next  = '0;
                quo_next  = COLOUR_SPAN;
                dcnt_next = DCNT_W'(COLOUR_W);
            end
            AL_DIV_STEP: begin
                rem_next  = take ? trial[CAP_W-1:0] : {rem_reg[CAP_W-2:0], quo_reg[COLOUR_W-1]};
                quo_next  = {quo_reg[COLOUR_W-2:0], take};
                dcnt_next = dcnt_reg - 1'b1;
            end
            AL_COL_MUL: prod_next = count * quo_reg;
            AL_COL_MOD: begin
                colour_next = (fold >= {1'b0, COLOUR_SPAN})
                            ? fold[COLOUR_W-1:0] - COLOUR_SPAN
                            : fold[COLOUR_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else begin
            dcnt_reg <= dcnt_next;
        end
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        prod_reg   <= prod_next;
        colour_reg <= colour_next;
    end

    assign div_more = (dcnt_reg != DCNT_W'(1));
    assign colour   = colour_reg;

    a_div_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        (alu == AL_DIV_STEP) |-> (dcnt_reg != '0))
        else $error("divider stepped without being started");

endmodule

`default_nettype wire

@@ test/tb_escape_time_fractal_pixel_top.sv @@
// Self-checking testbench for escape_time_fractal_pixel_top: directed pixels, then random phases.
// Predicts escape count and colour in fixed point of its own; needs etf_pkg and the block's RTL.

module tb_escape_time_fractal_pixel_top
    import etf_pkg::*;
;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 28;
    localparam int INDEX_W = 12;
    localparam int GUARD_W = COORD_W + 3;

    localparam logic [127:0] GUARD_MAX       = (128'd1 << (GUARD_W - 1)) - 128'd1;
    localparam longint       ESCAPE_RADIUS_SQ = longint'(4) <<< FRAC_W;
    localparam longint       SPAN            = longint'(COLOUR_SPAN);

    localparam int PLAN_LEN         = 27;
    localparam int RANDOM_PHASES    = 6;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int BACKLOG_AT       = 150;
    localparam int BACKLOG_CYCLES   = 600;
    localparam int TAIL_CYCLES      = 60;
    localparam int WATCHDOG_LIMIT   = 100000;

    // Register index the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Result fields, lowest bits first from the bottom up, as on m_tdata
    typedef struct packed {
        logic [15:0] escape_count;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } colour_result_t;

    localparam colour_result_t BLACK = '0;
    // c = 1.0, cap 65535: escapes on the third pass, colour 32 * 256
    localparam colour_result_t UNIT_C_RESULT =
        '{escape_count: 16'd2, blue: 8'h00, green: 8'h20, red: 8'h00};

    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [31:0]          value;
        logic [INDEX_W-1:0]   column;
        logic [INDEX_W-1:0]   row;
        logic                 typed;
        colour_result_t       want;
    } plan_row_t;

    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [COORD_W-1:0]            cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [23:0]                   s_tdata   = '0;   // column, row
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [OUT_W-1:0]              m_tdata;          // red, green, blue, escape_count

    // Shadow copy of the configuration registers
    logic [CAP_W-1:0]   cap_shadow      = ITER_CAP_RST;
    logic [COORD_W-1:0] x_origin_shadow = X_ORIGIN_RST[COORD_W-1:0];
    logic [COORD_W-1:0] y_origin_shadow = Y_ORIGIN_RST[COORD_W-1:0];
    logic [COORD_W-2:0] x_step_shadow   = X_STEP_RST[COORD_W-2:0];
    logic [COORD_W-2:0] y_step_shadow   = Y_STEP_RST[COORD_W-2:0];

    colour_result_t expected_colours[$];
    int             mismatches   = 0;
    int             results_seen = 0;
    int             quiet_cycles = 0;
    bit             feed_burst   = 1'b0;
    bit             sink_burst   = 1'b0;

    escape_time_fractal_pixel_top #(
        .COORD_WIDTH(COORD_W),
        .FRAC_BITS  (FRAC_W),
        .INDEX_WIDTH(INDEX_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Two's complement saturation to a given width
    function automatic longint saturate(input longint v, input int bits);
        longint top;
        longint bottom;
        top    = (longint'(1) <<< (bits - 1)) - 1;
        bottom = -top - 1;
        if (v > top) return top;
        if (v < bottom) return bottom;
        return v;
    endfunction

    // Fixed-point product: truncate toward zero, clip magnitude to guard width
    function automatic longint q_mul(input longint a, input longint b);
        logic [63:0]  mag_a;
        logic [63:0]  mag_b;
        logic [127:0] wide;
        bit           negative;
        negative = (a < 0) != (b < 0);
        mag_a    = (a < 0) ? -a : a;
        mag_b    = (b < 0) ? -b : b;
        wide     = {64'd0, mag_a} * {64'd0, mag_b};
        wide     = wide >> FRAC_W;
        if (wide > GUARD_MAX) wide = GUARD_MAX;
        return negative ? -longint'(wide[63:0]) : longint'(wide[63:0]);
    endfunction

    // One part of c: origin + index * step, offset clipped at 2^COORD_W
    function automatic longint plane_coord(input logic [COORD_W-1:0] origin,
                                           input logic [COORD_W-2:0] step,
                                           input logic [INDEX_W-1:0] index);
        longint offset;
        offset = longint'({52'd0, index}) * longint'({33'd0, step});
        if (offset > (longint'(1) <<< COORD_W)) offset = longint'(1) <<< COORD_W;
        return saturate(longint'($signed(origin)) + offset, COORD_W);
    endfunction

    // Escape count and colour of one pixel under the current registers
    function automatic colour_result_t predict_pixel(input logic [INDEX_W-1:0] column,
                                                     input logic [INDEX_W-1:0] row);
        longint         cr, ci, zr, zi, nr, ni;
        longint         passes, pass, hit, scaled;
        colour_result_t res;
        passes = (cap_shadow == '0) ? longint'(1) : longint'({48'd0, cap_shadow});
        cr     = plane_coord(x_origin_shadow, x_step_shadow, column);
        ci     = plane_coord(y_origin_shadow, y_step_shadow, row);
        zr     = 0;
        zi     = 0;
        hit    = 0;
        for (pass = 0; pass < passes; pass++) begin
            nr = saturate(q_mul(zr, zr) - q_mul(zi, zi) + cr, GUARD_W);
            ni = saturate(2 * q_mul(zr, zi) + ci, GUARD_W);
            if (q_mul(nr, nr) + q_mul(ni, ni) > ESCAPE_RADIUS_SQ) begin
                hit = pass;
                break;
            end
            zr = saturate(nr, COORD_W);
            zi = saturate(ni, COORD_W);
        end
        scaled           = (longint'(16) * hit * (SPAN / passes)) % SPAN;
        res.red          = scaled[7:0];
        res.green        = scaled[15:8];
        res.blue         = scaled[23:16];
        res.escape_count = hit[15:0];
        return res;
    endfunction

    function automatic plan_row_t pixel_row(input logic [INDEX_W-1:0] column,
                                            input logic [INDEX_W-1:0] row);
        plan_row_t r;
        r        = '0;
        r.column = column;
        r.row    = row;
        return r;
    endfunction

    function automatic plan_row_t typed_row(input logic [INDEX_W-1:0] column,
                                            input logic [INDEX_W-1:0] row,
                                            input colour_result_t want);
        plan_row_t r;
        r       = pixel_row(column, row);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [31:0] value);
        plan_row_t r;
        r           = '0;
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.value     = value;
        return r;
    endfunction

    // Register write, only once the block has returned every pixel
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        while (expected_colours.size() != 0) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_ITER_CAP: cap_shadow      = value[CAP_W-1:0];
            REG_X_ORIGIN: x_origin_shadow = value;
            REG_Y_ORIGIN: y_origin_shadow = value;
            REG_X_STEP:   x_step_shadow   = value[COORD_W-2:0];
            REG_Y_STEP:   y_step_shadow   = value[COORD_W-2:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one pixel after a random gap, or none in a burst; record its colour on acceptance
    task automatic send_pixel(input logic [INDEX_W-1:0] column, input logic [INDEX_W-1:0] row,
                              input logic typed, input colour_result_t want);
        int gap;
        gap = feed_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, column};
        do @(posedge aclk); while (s_tready !== 1'b1);
        expected_colours.push_back(typed ? want : predict_pixel(column, row));
        @(negedge aclk);
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Stimulus: reset, directed table, random phases, drain
    initial begin : stimulus
        plan_row_t            plan [0:PLAN_LEN-1];
        int                   k;
        int                   ph;
        logic [31:0]          cap_word, xo, yo, xs, ys;
        logic [INDEX_W-1:0]   col, row;

        plan = '{
            // default registers: corners escape on the first pass
            typed_row(12'd0, 12'd0, BLACK),
            typed_row(12'd4095, 12'd0, BLACK),
            typed_row(12'd0, 12'd4095, BLACK),
            typed_row(12'd4095, 12'd4095, BLACK),
            pixel_row(12'd915, 12'd366),        // inside the main cardioid
            pixel_row(12'd700, 12'd400),
            pixel_row(12'd500, 12'd120),
            // zero cap acts as a cap of one
            write_row(REG_ITER_CAP, 32'h0000_0000),
            typed_row(12'd915, 12'd366, BLACK),
            // widest cap, upper write bits ignored; c fixed at 1.0
            write_row(REG_ITER_CAP, 32'hFFFF_FFFF),
            write_row(REG_X_ORIGIN, 32'h1000_0000),
            write_row(REG_Y_ORIGIN, 32'h0000_0000),
            write_row(REG_X_STEP, 32'h0000_0000),
            write_row(REG_Y_STEP, 32'h0000_0000),
            typed_row(12'd4095, 12'd4095, UNIT_C_RESULT),
            // origin extremes, widest step, coordinates saturating
            write_row(REG_X_ORIGIN, 32'h8000_0000),
            write_row(REG_Y_ORIGIN, 32'h7FFF_FFFF),
            write_row(REG_X_STEP, 32'hFFFF_FFFF),
            write_row(REG_UNUSED, 32'hDEAD_BEEF),
            typed_row(12'd0, 12'd0, BLACK),
            typed_row(12'd4095, 12'd0, BLACK),
            pixel_row(12'd2, 12'd0),
            // c = -2 at column 0 stays bounded under a short cap; column 1 escapes
            write_row(REG_ITER_CAP, 32'h0000_0003),
            write_row(REG_X_ORIGIN, 32'hE000_0000),
            write_row(REG_Y_ORIGIN, 32'h0000_0000),
            pixel_row(12'd0, 12'd0),
            pixel_row(12'd1, 12'd0)
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (k = 0; k < PLAN_LEN; k++) begin
            if (plan[k].is_write) begin
                cfg_write(plan[k].reg_index, plan[k].value);
            end else begin
                send_pixel(plan[k].column, plan[k].row, plan[k].typed, plan[k].want);
            end
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 3)
                0: begin
                    // view around the set, short caps
                    cap_word = $urandom_range(1, 40);
                    xo = 32'hD800_0000 + $urandom_range(0, 32'h0800_0000);
                    yo = 32'hE800_0000 + $urandom_range(0, 32'h1000_0000);
                    xs = $urandom_range(0, 800000);
                    ys = $urandom_range(0, 600000);
                end
                1: begin
                    // long caps, c right of the set so every pixel escapes soon
                    cap_word = ($urandom_range(0, 1) == 1) ? 32'h0000_FFFF
                                                           : $urandom_range(1000, 65535);
                    xo = 32'h1000_0000 + $urandom_range(0, 32'h1000_0000);
                    yo = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
                    xs = $urandom_range(0, 65536);
                    ys = $urandom_range(0, 65536);
                end
                default: begin
                    // anything goes, junk in the unused write bits
                    cap_word = ($urandom_range(0, 65535) << 16) | $urandom_range(0, 24);
                    xo = $urandom;
                    yo = $urandom;
                    xs = $urandom;
                    ys = $urandom;
                end
            endcase
            cfg_write(REG_ITER_CAP, cap_word);
            cfg_write(REG_X_ORIGIN, xo);
            cfg_write(REG_Y_ORIGIN, yo);
            cfg_write(REG_X_STEP, xs);
            cfg_write(REG_Y_STEP, ys);
            feed_burst = ($urandom_range(0, 3) == 0);
            repeat (RANDOM_PER_PHASE) begin
                if (ph % 3 == 0 && $urandom_range(0, 4) != 0) begin
                    col = INDEX_W'($urandom_range(0, 1023));
                    row = INDEX_W'($urandom_range(0, 1023));
                end else begin
                    col = INDEX_W'($urandom_range(0, 4095));
                    row = INDEX_W'($urandom_range(0, 4095));
                end
                send_pixel(col, row, 1'b0, BLACK);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_colours.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("tb_escape_time_fractal_pixel_top: clean");
        end else begin
            $display("tb_escape_time_fractal_pixel_top: errors");
        end
        $finish;
    end

    // Result side: random hold-offs, one long backlog, field-by-field check
    initial begin : result_sink
        int             gap;
        colour_result_t got;
        colour_result_t want;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (results_seen % 40 == 0) sink_burst = ($urandom_range(0, 3) == 0);
            if (results_seen == BACKLOG_AT) begin
                gap = BACKLOG_CYCLES;
            end else begin
                gap = sink_burst ? 0 : $urandom_range(0, 17);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got = colour_result_t'(m_tdata);
            if (expected_colours.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transaction, expected none, got %h", $time, got);
            end else begin
                want = expected_colours.pop_front();
                compare_field("red", 16'(want.red), 16'(got.red));
                compare_field("green", 16'(want.green), 16'(got.green));
                compare_field("blue", 16'(want.blue), 16'(got.blue));
                compare_field("escape_count", want.escape_count, got.escape_count);
            end
            results_seen++;
            @(negedge aclk);
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_escape_time_fractal_pixel_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ files.f @@
hdl/etf_pkg.sv
hdl/etf_mul.sv
hdl/etf_seq.sv
hdl/etf_colour.sv
hdl/escape_time_fractal_pixel_top.sv
test/tb_escape_time_fractal_pixel_top.sv
